// ===== src/vad_pkg.sv =====
// ----------------------------------------------------------------------------
// vad_pkg
// Shared types and constants of the energy voice activity detector.
// ----------------------------------------------------------------------------
package vad_pkg;

  // Default longest frame that is accumulated
  localparam int MAX_FRAME_SAMPLES_DEF = 1024;

  // Sample and result widths
  localparam int SAMPLE_W = 16;
  localparam int ENERGY_W = 16;
  localparam int SQ_W     = 31;  // square of a 16-bit sample, up to 2^30

  // Mean of squares in Q16 fits 47 bits; sqrt input padded to an even width
  localparam int MEAN_W   = 48;
  localparam int RMS_W    = MEAN_W / 2;  // RMS in Q8
  localparam int SREM_W   = RMS_W + 3;

  // Levels (unsigned Q17.8); threshold may reach 3x a level
  localparam int LVL_W    = 25;
  localparam int THR_W    = LVL_W + 1;
  localparam int WGT_W    = 16;
  localparam int PROD_W   = LVL_W + WGT_W;
  localparam int ACC_W    = PROD_W + 1;

  // Configuration port
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int FLOOR_W    = 15;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_END_SILENCE  = 8'd0,
    REG_THRESH_FLOOR = 8'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DEC_SILENCE = 2'd0,
    DEC_SPEECH  = 2'd1,
    DEC_END     = 2'd2
  } decision_t;

  // Reset values
  localparam logic [15:0]      END_SILENCE_RST = 16'd100;
  localparam logic [FLOOR_W-1:0] FLOOR_RST     = 15'd500;
  localparam logic [LVL_W-1:0] NOISE_RST       = 25'(500 * 256);
  localparam logic [LVL_W-1:0] SPEECH_RST      = 25'(5000 * 256);
  localparam logic [THR_W-1:0] THR_RST         = 26'(3000 * 256);

  // Q0.16 blend weights
  localparam logic [WGT_W-1:0] W_SPEECH_OLD = 16'd62259;
  localparam logic [WGT_W-1:0] W_SPEECH_NEW = 16'd3277;
  localparam logic [WGT_W-1:0] W_NOISE_OLD  = 16'd64225;
  localparam logic [WGT_W-1:0] W_NOISE_NEW  = 16'd1311;
  localparam logic [ACC_W-1:0] ROUND_HALF   = ACC_W'(32768);

endpackage

// ===== src/vad_ifs.sv =====
// ----------------------------------------------------------------------------
// vad_ifs
// Valid/ready channels of the detector: samples, decisions, register writes.
// ----------------------------------------------------------------------------
interface vad_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [vad_pkg::SAMPLE_W-1:0] sample;
  logic                              frame_last;

  modport source (output valid, output sample, output frame_last, input ready);
  modport sink   (input valid, input sample, input frame_last, output ready);
endinterface

interface vad_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    decision;
  logic [vad_pkg::ENERGY_W-1:0]  frame_energy;

  modport source (output valid, output decision, output frame_energy, input ready);
  modport sink   (input valid, input decision, input frame_energy, output ready);
endinterface

interface vad_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vad_pkg::CFG_ADDR_W-1:0]  addr;
  logic [vad_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== src/energy_voice_activity_detector_top.sv =====
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_top
// Energy voice activity detector: one decision per audio frame.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the two-frame queue has room; each
// frame_last request closes the frame and later yields one decision with the
// integer RMS. The back end works a frame through the queue pop, a serial
// divide for the mean of squares, a serial square root, classify, blend and
// the level update, which waits for a free output; it takes no new frame
// until the last one is done, so short frames fill the queue and stall
// sample input.
// Register 0 is end_silence_frames, register 1 threshold_floor; write them
// only while the detector is idle.
module energy_voice_activity_detector_top #(
  parameter int MAX_FRAME_SAMPLES = vad_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  vad_in_if.sink     in_ch,
  vad_out_if.source  out_ch,
  vad_cfg_if.sink    cfg_ch
);

  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W = CNT_W + 30;

  logic [15:0]                 end_sil_r;
  logic [vad_pkg::FLOOR_W-1:0] floor_r;
  logic                        push, full, pop_valid, pop;
  logic [SUM_W-1:0]            push_sum, pop_sum;
  logic [CNT_W-1:0]            push_cnt, pop_cnt;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_sil_r <= vad_pkg::END_SILENCE_RST;
      floor_r   <= vad_pkg::FLOOR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        vad_pkg::REG_END_SILENCE:  end_sil_r <= cfg_ch.data;
        vad_pkg::REG_THRESH_FLOOR: floor_r   <= cfg_ch.data[vad_pkg::FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  vad_front #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
    .CNT_W             (CNT_W),
    .SUM_W             (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push     (push),
    .full     (full),
    .push_sum (push_sum),
    .push_cnt (push_cnt)
  );

  vad_fifo #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .push_sum  (push_sum),
    .push_cnt  (push_cnt),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_sum   (pop_sum),
    .pop_cnt   (pop_cnt)
  );

  vad_back #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
    .CNT_W             (CNT_W),
    .SUM_W             (SUM_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop         (pop),
    .pop_sum     (pop_sum),
    .pop_cnt     (pop_cnt),
    .end_silence (end_sil_r),
    .thr_floor   (floor_r),
    .out_ch      (out_ch)
  );

endmodule

// ===== src/vad_front.sv =====
// ----------------------------------------------------------------------------
// vad_front
// Sample front end: squares each sample, sums up to MAX_FRAME_SAMPLES of a frame, hands the
// closed frame (sum of squares, count) to the frame queue.
// ----------------------------------------------------------------------------
module vad_front #(
  parameter int MAX_FRAME_SAMPLES = vad_pkg::MAX_FRAME_SAMPLES_DEF,
  parameter int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1),
  parameter int SUM_W = CNT_W + 30
) (
  input  logic             clk,
  input  logic             rst_n,
  vad_in_if.sink           in_ch,
  output logic             push,
  input  logic             full,
  output logic [SUM_W-1:0] push_sum,
  output logic [CNT_W-1:0] push_cnt
);

  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_frame;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_frame;
  logic signed [31:0] sq_s;
  logic               acc_en;
  logic               accept;

  // square of the incoming sample
  assign sq_s   = in_ch.sample * in_ch.sample;
  assign acc_en = (cnt_r < CNT_W'(MAX_FRAME_SAMPLES));

  assign sum_frame = acc_en ? sum_r + SUM_W'(sq_s[vad_pkg::SQ_W-1:0]) : sum_r;
  assign cnt_frame = acc_en ? cnt_r + CNT_W'(1) : cnt_r;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && in_ch.frame_last;
  assign push_sum    = sum_frame;
  assign push_cnt    = cnt_frame;

  // accumulate, clear at frame close
  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_ch.frame_last) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_frame;
        cnt_nxt = cnt_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/vad_fifo.sv =====
// ----------------------------------------------------------------------------
// vad_fifo
// Two-entry queue of closed frames between front end and back end.
// ----------------------------------------------------------------------------
module vad_fifo #(
  parameter int CNT_W = 11,
  parameter int SUM_W = 41
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [SUM_W-1:0] push_sum,
  input  logic [CNT_W-1:0] push_cnt,
  output logic             pop_valid,
  input  logic             pop,
  output logic [SUM_W-1:0] pop_sum,
  output logic [CNT_W-1:0] pop_cnt
);

  logic [SUM_W-1:0] sum_mem [2];
  logic [CNT_W-1:0] cnt_mem [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign full      = (fill_r == 2'd2);
  assign pop_valid = (fill_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_sum   = sum_mem[rd_ptr_r];
  assign pop_cnt   = cnt_mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      sum_mem[wr_ptr_r] <= push_sum;
      cnt_mem[wr_ptr_r] <= push_cnt;
    end
  end

  // pointers and fill level
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== src/vad_back.sv =====
// ----------------------------------------------------------------------------
// vad_back
// Frame back end: serial divide for the mean of squares, serial square root,
// level blend and the speech / silence / end decision.
// ----------------------------------------------------------------------------
module vad_back #(
  parameter int MAX_FRAME_SAMPLES = vad_pkg::MAX_FRAME_SAMPLES_DEF,
  parameter int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1),
  parameter int SUM_W = CNT_W + 30
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop,
  input  logic [SUM_W-1:0]             pop_sum,
  input  logic [CNT_W-1:0]             pop_cnt,
  input  logic [15:0]                  end_silence,
  input  logic [vad_pkg::FLOOR_W-1:0]  thr_floor,
  vad_out_if.source                    out_ch
);

  localparam int DW    = SUM_W + 16;
  localparam int DCW   = $clog2(DW);
  localparam int RMS_W = vad_pkg::RMS_W;
  localparam int SCW   = $clog2(RMS_W);
  localparam int LVL_W = vad_pkg::LVL_W;
  localparam int THR_W = vad_pkg::THR_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_SQRT = 6'b000100,
    ST_MUL1 = 6'b001000,
    ST_MUL2 = 6'b010000,
    ST_UPD  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // divider
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] drem_r, drem_nxt;
  logic [DCW-1:0]   dcnt_r, dcnt_nxt;
  logic [CNT_W:0]   drem_sh;
  logic             dge;

  // square root
  logic [vad_pkg::MEAN_W-1:0] rad_r, rad_nxt;
  logic [vad_pkg::SREM_W-1:0] srem_r, srem_nxt, srem_sh, strial;
  logic [RMS_W-1:0]           root_r, root_nxt;
  logic [SCW-1:0]             scnt_r, scnt_nxt;
  logic                       sge;

  // blend
  logic                       spch_r, spch_nxt;
  logic [vad_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [LVL_W-1:0]           blend_r, blend_nxt;
  logic [vad_pkg::ACC_W-1:0]  acc;

  // detector state
  logic [LVL_W-1:0] noise_r, noise_nxt;
  logic [LVL_W-1:0] speech_r, speech_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [15:0]      run_r, run_nxt;
  logic             seeded_r, seeded_nxt;
  logic             pend_r, pend_nxt;

  // output register
  logic                         ovalid_r, ovalid_nxt;
  logic [1:0]                   odec_r, odec_nxt;
  logic [vad_pkg::ENERGY_W-1:0] oen_r, oen_nxt;

  logic             out_free;
  logic [THR_W-1:0] t3, tfl, tmid, tlow;
  logic [15:0]      run_inc;

  assign out_ch.valid        = ovalid_r;
  assign out_ch.decision     = odec_r;
  assign out_ch.frame_energy = oen_r;
  assign out_free            = !ovalid_r || out_ch.ready;
  assign pop                 = (state_r == ST_IDLE) && pop_valid;

  // restoring divide step
  assign drem_sh = {drem_r, quo_r[DW-1]};
  assign dge     = (drem_sh >= {1'b0, dvs_r});

  // square root step, two radicand bits a step
  assign srem_sh = {srem_r[vad_pkg::SREM_W-3:0], rad_r[vad_pkg::MEAN_W-1 -: 2]};
  assign strial  = vad_pkg::SREM_W'({root_r, 2'b01});
  assign sge     = (srem_sh >= strial);

  // blend accumulate with rounding
  assign acc = vad_pkg::ACC_W'(prod_r)
             + vad_pkg::ACC_W'(root_r * (spch_r ? vad_pkg::W_SPEECH_NEW
                                                : vad_pkg::W_NOISE_NEW))
             + vad_pkg::ROUND_HALF;

  // threshold candidates
  assign t3      = THR_W'(root_r) + (THR_W'(root_r) << 1);
  assign tfl     = THR_W'(thr_floor) << 8;
  assign tmid    = (THR_W'(blend_r) + THR_W'(speech_r)) >> 1;
  assign tlow    = THR_W'(blend_r) + THR_W'(blend_r >> 1);
  assign run_inc = (run_r == 16'hFFFF) ? run_r : run_r + 16'd1;

  always_comb begin
    state_nxt  = state_r;
    quo_nxt    = quo_r;
    dvs_nxt    = dvs_r;
    drem_nxt   = drem_r;
    dcnt_nxt   = dcnt_r;
    rad_nxt    = rad_r;
    srem_nxt   = srem_r;
    root_nxt   = root_r;
    scnt_nxt   = scnt_r;
    spch_nxt   = spch_r;
    prod_nxt   = prod_r;
    blend_nxt  = blend_r;
    noise_nxt  = noise_r;
    speech_nxt = speech_r;
    thr_nxt    = thr_r;
    run_nxt    = run_r;
    seeded_nxt = seeded_r;
    pend_nxt   = pend_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    odec_nxt   = odec_r;
    oen_nxt    = oen_r;

    case (state_r)
      // take a closed frame from the queue
      ST_IDLE: begin
        if (pop_valid) begin
          if (pop_cnt == '0) begin
            quo_nxt = '0;
            dvs_nxt = CNT_W'(1);
          end else begin
            quo_nxt = {pop_sum, 16'b0};
            dvs_nxt = pop_cnt;
          end
          drem_nxt  = '0;
          dcnt_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      // one quotient bit a cycle
      ST_DIV: begin
        drem_nxt = dge ? CNT_W'(drem_sh - {1'b0, dvs_r}) : drem_sh[CNT_W-1:0];
        quo_nxt  = {quo_r[DW-2:0], dge};
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(DW - 1)) begin
          rad_nxt   = vad_pkg::MEAN_W'({quo_r[DW-2:0], dge});
          srem_nxt  = '0;
          root_nxt  = '0;
          scnt_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      // one root bit a cycle
      ST_SQRT: begin
        srem_nxt = sge ? srem_sh - strial : srem_sh;
        root_nxt = {root_r[RMS_W-2:0], sge};
        rad_nxt  = rad_r << 2;
        scnt_nxt = scnt_r + SCW'(1);
        if (scnt_r == SCW'(RMS_W - 1)) begin
          state_nxt = ST_MUL1;
        end
      end
      // classify and weight the old level
      ST_MUL1: begin
        spch_nxt  = seeded_r && (THR_W'(root_r) > thr_r);
        prod_nxt  = spch_nxt ? speech_r * vad_pkg::W_SPEECH_OLD
                             : noise_r * vad_pkg::W_NOISE_OLD;
        state_nxt = ST_MUL2;
      end
      // add the weighted new value
      ST_MUL2: begin
        blend_nxt = acc[vad_pkg::PROD_W-1:16];
        state_nxt = ST_UPD;
      end
      // update levels and emit the decision
      ST_UPD: begin
        if (out_free) begin
          oen_nxt    = root_r[RMS_W-1:8];
          ovalid_nxt = 1'b1;
          if (!seeded_r) begin
            noise_nxt  = LVL_W'(root_r);
            speech_nxt = LVL_W'(root_r);
            thr_nxt    = (t3 < tfl) ? tfl : t3;
            seeded_nxt = 1'b1;
            odec_nxt   = vad_pkg::DEC_SILENCE;
          end else if (spch_r) begin
            speech_nxt = blend_r;
            run_nxt    = '0;
            pend_nxt   = 1'b1;
            odec_nxt   = vad_pkg::DEC_SPEECH;
          end else begin
            noise_nxt = blend_r;
            thr_nxt   = (tmid < tlow) ? tlow : tmid;
            run_nxt   = run_inc;
            odec_nxt  = vad_pkg::DEC_SILENCE;
            if (pend_r && (run_inc >= end_silence)) begin
              pend_nxt = 1'b0;
              odec_nxt = vad_pkg::DEC_END;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    dvs_r   <= dvs_nxt;
    drem_r  <= drem_nxt;
    dcnt_r  <= dcnt_nxt;
    rad_r   <= rad_nxt;
    srem_r  <= srem_nxt;
    root_r  <= root_nxt;
    scnt_r  <= scnt_nxt;
    spch_r  <= spch_nxt;
    prod_r  <= prod_nxt;
    blend_r <= blend_nxt;
    odec_r  <= odec_nxt;
    oen_r   <= oen_nxt;
  end

  // control and detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      noise_r  <= vad_pkg::NOISE_RST;
      speech_r <= vad_pkg::SPEECH_RST;
      thr_r    <= vad_pkg::THR_RST;
      run_r    <= '0;
      seeded_r <= 1'b0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      noise_r  <= noise_nxt;
      speech_r <= speech_nxt;
      thr_r    <= thr_nxt;
      run_r    <= run_nxt;
      seeded_r <= seeded_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

`ifndef ASSERT_OFF
  // RMS of 16-bit samples never exceeds 32768.0 in Q8
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL1) |-> (root_r <= RMS_W'(32768 * 256)))
    else $error("square root out of range");

  // once seeded, the threshold stays at or above 1.5x noise
  a_thr_low: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |-> (thr_r >= THR_W'(noise_r) + THR_W'(noise_r >> 1)))
    else $error("threshold below noise bound");

  // a free output slot is filled when the update runs
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && !ovalid_r) |=> (ovalid_r && state_r == ST_IDLE))
    else $error("decision not loaded");

  // end of utterance goes out exactly when pending speech is cleared
  a_end_once: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(pend_r) && $past(rst_n)) |-> (ovalid_r && odec_r == vad_pkg::DEC_END))
    else $error("pending speech cleared without end decision");
`endif

endmodule

// ===== verif/energy_voice_activity_detector_top_test.sv =====
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_top_test
// Streams framed audio samples into the detector and checks every decision
// and frame energy against a cycle-free model of the frame statistics and
// the adaptive noise/speech levels. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_top_test;

  localparam int MAX_FRAME = vad_pkg::MAX_FRAME_SAMPLES_DEF;

  typedef struct packed {
    vad_pkg::decision_t decision;
    logic [15:0]        energy;
  } frame_verdict_t;

  logic clk;
  logic rst_n;

  vad_in_if  in_ch();
  vad_out_if out_ch();
  vad_cfg_if cfg_ch();

  energy_voice_activity_detector_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Detector state mirror
  logic [15:0] end_frames;
  logic [14:0] floor_int;
  logic [63:0] sq_acc;
  int unsigned smp_cnt;
  logic [31:0] noise_lvl, speech_lvl, thresh_lvl;
  int unsigned quiet_run;
  bit          levels_seeded, utterance_open;

  frame_verdict_t verdict_q[$];
  int  mismatches;
  int  unexpected;
  bit  hold_off;   // long receiver stall
  bit  sink_quiet; // run without receiver stalls

  function automatic logic [31:0] root64(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] mix_level(input logic [31:0] prev, input logic [15:0] wp,
                                            input logic [31:0] cur, input logic [15:0] wc);
    logic [63:0] acc;
    acc = 64'(prev) * wp + 64'(cur) * wc + 64'd32768;
    return 32'(acc >> 16) & 32'h1FF_FFFF;
  endfunction

  // Advance the mirror by one sample; queue a verdict on frame close
  task automatic track_sample(input logic [15:0] smp, input bit last);
    int s;
    logic [63:0] mean;
    logic [31:0] rms, low;
    vad_pkg::decision_t dec;
    s = $signed(smp);
    if (smp_cnt < MAX_FRAME) begin
      sq_acc = sq_acc + 64'(s * s);
      smp_cnt++;
    end
    if (!last) return;
    mean = smp_cnt != 0 ? (sq_acc << 16) / smp_cnt : 0;
    rms = root64(mean);
    sq_acc = 0;
    smp_cnt = 0;
    if (!levels_seeded) begin
      noise_lvl = rms;
      speech_lvl = rms;
      thresh_lvl = rms * 3;
      if (thresh_lvl < (32'(floor_int) << 8)) thresh_lvl = 32'(floor_int) << 8;
      levels_seeded = 1;
      dec = vad_pkg::DEC_SILENCE;
    end else if (rms > thresh_lvl) begin
      speech_lvl = mix_level(speech_lvl, vad_pkg::W_SPEECH_OLD, rms, vad_pkg::W_SPEECH_NEW);
      quiet_run = 0;
      utterance_open = 1;
      dec = vad_pkg::DEC_SPEECH;
    end else begin
      noise_lvl = mix_level(noise_lvl, vad_pkg::W_NOISE_OLD, rms, vad_pkg::W_NOISE_NEW);
      thresh_lvl = (noise_lvl + speech_lvl) >> 1;
      low = noise_lvl + (noise_lvl >> 1);
      if (thresh_lvl < low) thresh_lvl = low;
      if (quiet_run < 65535) quiet_run++;
      dec = vad_pkg::DEC_SILENCE;
      if (utterance_open && quiet_run >= end_frames) begin
        utterance_open = 0;
        dec = vad_pkg::DEC_END;
      end
    end
    verdict_q.push_back('{decision: dec, energy: rms[23:8]});
  endtask

  // Mostly none, some short gaps, few long; request drops only for a real gap
  task automatic random_gap();
    int n;
    n = 0;
    case ($urandom_range(0, 9)) inside
      [0:2]:   n = $urandom_range(1, 3);
      3:       n = $urandom_range(10, 40);
      default: n = 0;
    endcase
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Send one sample request and update the mirror on acceptance
  task automatic send_sample(input logic [15:0] smp, input bit last, input bit gaps);
    if (gaps) random_gap();
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= smp;
    in_ch.frame_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_sample(smp, last);
    @(negedge clk);
  endtask

  task automatic write_reg(input vad_pkg::cfg_reg_t idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == vad_pkg::REG_END_SILENCE) end_frames = val;
    else floor_int = val[14:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until all decisions are back, then let the back end settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic send_frame(input int len, input int amp, input bit gaps);
    for (int i = 0; i < len; i++) begin
      logic [15:0] v;
      v = 16'($signed($urandom_range(0, 2 * amp)) - amp);
      send_sample(v, i == len - 1, gaps);
    end
  endtask

  // Extremes of the sample field, seeding at reset floor, oversize frame
  task automatic test_directed();
    send_sample(16'h8000, 1, 0);          // seed with full-scale negative
    send_sample(16'h7FFF, 0, 0);
    send_sample(16'h8000, 1, 0);
    send_sample(16'h0000, 1, 0);          // zero-energy frame
    send_sample(16'h0001, 0, 0);
    send_sample(16'hFFFF, 1, 0);
    send_sample(16'h7FFF, 1, 0);          // full-scale positive
    send_sample(16'h5555, 0, 0);
    send_sample(16'hAAAA, 1, 0);
    for (int i = 0; i < 4; i++) send_sample(16'h0003, 1, 0);
    drain();
    // oversized frame: samples past the limit are dropped
    for (int i = 0; i < MAX_FRAME + 6; i++)
      send_sample(i < MAX_FRAME ? 16'h0010 : 16'h7FFF, i == MAX_FRAME + 5, 0);
    drain();
  endtask

  // Set end count and floor; at zero count, end on first silence after speech
  task automatic test_end_of_utterance(input logic [15:0] endc, input logic [14:0] flr);
    write_reg(vad_pkg::REG_END_SILENCE, endc);
    write_reg(vad_pkg::REG_THRESH_FLOOR, 16'(flr));
    for (int k = 0; k < 6; k++) begin
      send_frame($urandom_range(1, 6), 30000, 1);
      for (int j = 0; j < int'(endc) + 2 && j < 12; j++)
        send_frame($urandom_range(1, 6), $urandom_range(0, 50), 1);
    end
    drain();
  endtask

  // Receiver holds off long; sender keeps offering so the input stalls
  task automatic test_backpressure();
    hold_off = 1;
    for (int i = 0; i < 40; i++) send_sample(16'($urandom), 1, 0);
    drain();
  endtask

  // Random frames of random length, loud and quiet mixed at random
  task automatic test_random(input int items);
    int sent;
    int len, amp;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      case ($urandom_range(0, 3))
        0:       amp = $urandom_range(8000, 32767);
        1:       amp = $urandom_range(0, 200);
        2:       amp = $urandom_range(0, 3000);
        default: amp = $urandom_range(0, 32767);
      endcase
      sink_quiet = ($urandom_range(0, 7) == 0);
      send_frame(len, amp, 1);
      sent += len;
    end
    drain();
    sink_quiet = 0;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected decision %0d energy %0d", out_ch.decision, out_ch.frame_energy);
      end else begin
        frame_verdict_t exp_v;
        exp_v = verdict_q.pop_front();
        if (out_ch.decision !== exp_v.decision || out_ch.frame_energy !== exp_v.energy) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("decision exp %0d got %0d, energy exp %0d got %0d",
                     exp_v.decision, out_ch.decision, exp_v.energy, out_ch.frame_energy);
        end
      end
    end
  end

  // Receiver readiness, with random stalls and one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (sink_quiet) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 9) > 2);
    end
  end

  initial begin : hold_off_counter
    int n;
    wait (hold_off);
    n = 0;
    while (n < 600) begin
      @(negedge clk);
      n++;
    end
    hold_off = 0;
  end

  // Limit
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 0; in_ch.sample = 0; in_ch.frame_last = 0;
    cfg_ch.valid = 0; cfg_ch.addr = vad_pkg::REG_END_SILENCE; cfg_ch.data = 0;
    out_ch.ready = 0;
    hold_off = 0; sink_quiet = 0;
    mismatches = 0; unexpected = 0;
    end_frames = vad_pkg::END_SILENCE_RST; floor_int = vad_pkg::FLOOR_RST;
    sq_acc = 0; smp_cnt = 0;
    noise_lvl = 32'(vad_pkg::NOISE_RST);
    speech_lvl = 32'(vad_pkg::SPEECH_RST);
    thresh_lvl = 32'(vad_pkg::THR_RST);
    quiet_run = 0; levels_seeded = 0; utterance_open = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_end_of_utterance(16'd0, 15'd0);
    test_end_of_utterance(16'd3, 15'd32767);
    test_backpressure();
    write_reg(vad_pkg::REG_END_SILENCE, 16'd65535);
    test_random(200);
    test_end_of_utterance(16'd1, 15'd1000);
    test_random(300);

    if (mismatches == 0 && unexpected == 0 && verdict_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== energy_voice_activity_detector_top.f =====
src/vad_pkg.sv
src/vad_ifs.sv
src/vad_front.sv
src/vad_fifo.sv
src/vad_back.sv
src/energy_voice_activity_detector_top.sv
verif/energy_voice_activity_detector_top_test.sv
